// ===== rtl/imu_pkt_pkg.sv =====
// Shared types, constants and helper functions for the IMU packet parser.
// Used by imu_pkt_seek, imu_pkt_parser and imu_binary_packet_parser.
`timescale 1ns / 1ps
`default_nettype none

package imu_pkt_pkg;

    localparam int NUM_GROUPS = 7;
    localparam int MAX_TYPES  = 16;
    localparam int GRP_W      = 3;
    localparam int TYPE_W     = 4;
    localparam int BIDX_W     = 5;
    localparam int CNT_W      = 16;

    localparam logic [7:0] SYNC_BYTE = 8'hFA;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SYNC,
        ST_CRC,
        ST_UNSUP,
        ST_TRUNC
    } status_t;

    typedef logic [MAX_TYPES-1:0] tmask_t;
    typedef logic [NUM_GROUPS-1:0][MAX_TYPES-1:0] avail_t;

    typedef struct packed {
        logic              found;
        logic [GRP_W-1:0]  grp;
        logic [TYPE_W-1:0] typ;
    } seek_t;

    typedef struct packed {
        logic              kind;
        logic [GRP_W-1:0]  group_index;
        logic [TYPE_W-1:0] type_index;
        logic [BIDX_W-1:0] byte_index;
        logic [7:0]        payload_byte;
        status_t           packet_status;
        logic [CNT_W-1:0]  packets_seen;
        logic [CNT_W-1:0]  errors_seen;
    } result_t;

    localparam logic [BIDX_W-1:0] GRP_SIZE [0:7] = '{
        5'd15, 5'd10, 5'd12, 5'd16, 5'd9, 5'd11, 5'd16, 5'd0
    };

    localparam logic [BIDX_W-1:0] TYPE_LEN [0:7][0:15] = '{
        '{5'd8, 5'd8, 5'd8, 5'd12, 5'd16, 5'd12, 5'd24, 5'd12,
          5'd12, 5'd24, 5'd20, 5'd28, 5'd2, 5'd4, 5'd8, 5'd0},
        '{5'd8, 5'd8, 5'd8, 5'd2, 5'd8, 5'd8, 5'd8, 5'd4,
          5'd4, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd12, 5'd12, 5'd12, 5'd4, 5'd4, 5'd16, 5'd12,
          5'd12, 5'd12, 5'd12, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd8, 5'd8, 5'd2, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0,
          5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
          5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd2, 5'd24, 5'd24, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12,
          5'd12, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd8, 5'd2, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0,
          5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
          5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}
    };

    // type bits a group may carry: below its size and of nonzero length
    function automatic tmask_t legal_mask(input logic [GRP_W-1:0] g);
        tmask_t m;
        m = '0;
        for (int t = 0; t < MAX_TYPES; t++)
        begin
            m[t] = (BIDX_W'(t) < GRP_SIZE[g]) && (TYPE_LEN[g][t] != '0);
        end
        return m;
    endfunction

    function automatic logic [TYPE_W-1:0] ffs_type(input tmask_t v);
        tmask_t            lsb;
        logic [TYPE_W-1:0] idx;
        lsb = v & (~v + tmask_t'(1));
        idx = '0;
        for (int i = 0; i < MAX_TYPES; i++)
        begin
            if (lsb[i])
            begin
                idx = idx | TYPE_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [GRP_W-1:0] ffs_group(input logic [NUM_GROUPS-1:0] v);
        logic [NUM_GROUPS-1:0] lsb;
        logic [GRP_W-1:0]      idx;
        lsb = v & (~v + {{(NUM_GROUPS-1){1'b0}}, 1'b1});
        idx = '0;
        for (int i = 0; i < NUM_GROUPS; i++)
        begin
            if (lsb[i])
            begin
                idx = idx | GRP_W'(i);
            end
        end
        return idx;
    endfunction

    // CRC-16/XMODEM, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = {c_in[7:0], c_in[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/imu_pkt_seek.sv =====
// Next-field search: first set type bit at or after (from_group, from_type).
// Depends on imu_pkt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_pkt_seek
    import imu_pkt_pkg::*;
(
    input  avail_t              avail,
    input  logic [GRP_W-1:0]    from_group,
    input  logic [TYPE_W:0]     from_type,
    output seek_t               result
);

    tmask_t                rows [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] row_any;
    tmask_t                sel_row;
    logic [GRP_W-1:0]      first_grp;

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (GRP_W'(g) == from_group)
            begin
                rows[g] = avail[g] & ({MAX_TYPES{1'b1}} << from_type);
            end
            else if (GRP_W'(g) > from_group)
            begin
                rows[g] = avail[g];
            end
            else
            begin
                rows[g] = '0;
            end
            row_any[g] = |rows[g];
        end

        first_grp = ffs_group(row_any);

        sel_row = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (GRP_W'(g) == first_grp)
            begin
                sel_row = rows[g];
            end
        end

        result.found = |row_any;
        result.grp   = first_grp;
        result.typ   = ffs_type(sel_row);
    end

endmodule

`default_nettype wire

// ===== rtl/imu_pkt_parser.sv =====
// Packet state, CRC and counters; decodes one byte per step with a result
// per data byte and at eop. Depends on imu_pkt_pkg and imu_pkt_seek.
`timescale 1ns / 1ps
`default_nettype none

module imu_pkt_parser
    import imu_pkt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       eop,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_GMASK,
        PH_TMASK,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [NUM_GROUPS-1:0] groups_reg, groups_next;
    avail_t                masks_reg, masks_next;
    logic                  mask_odd_reg, mask_odd_next;
    logic [GRP_W-1:0]      cur_group_reg, cur_group_next;
    logic [TYPE_W-1:0]     cur_type_reg, cur_type_next;
    logic [BIDX_W-1:0]     bif_reg, bif_next;
    logic [15:0]           crc_reg, crc_next;
    status_t               err_reg, err_next;
    logic [CNT_W-1:0]      pkt_cnt_reg, pkt_cnt_next;
    logic [CNT_W-1:0]      err_cnt_reg, err_cnt_next;

    logic [15:0]           crc_upd;
    status_t               err_upd;
    logic [NUM_GROUPS-1:0] tm_rest;
    logic [GRP_W:0]        grp_after;
    logic [7:0]            cur_lo;
    tmask_t                cur_mask_new;
    logic                  unsup;
    logic                  start_payload;
    avail_t                avail;
    logic [GRP_W-1:0]      seek_group;
    logic [TYPE_W:0]       seek_type;
    seek_t                 seek;
    logic [BIDX_W-1:0]     bif_inc;
    status_t               status;

    // header decode: CRC update, masks, error code and the search request
    always_comb
    begin
        crc_upd   = crc16_step(crc_reg, rx_byte);
        grp_after = {1'b0, cur_group_reg} + {{GRP_W{1'b0}}, 1'b1};
        tm_rest   = groups_reg & ({NUM_GROUPS{1'b1}} << grp_after);

        cur_lo = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (GRP_W'(g) == cur_group_reg)
            begin
                cur_lo = masks_reg[g][7:0];
            end
        end
        cur_mask_new = {rx_byte, cur_lo};
        unsup        = |(cur_mask_new & ~legal_mask(cur_group_reg));

        masks_next = masks_reg;
        if (phase_reg == PH_TMASK)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                if (GRP_W'(g) == cur_group_reg)
                begin
                    masks_next[g] = mask_odd_reg ? cur_mask_new : {8'h00, rx_byte};
                end
            end
        end

        groups_next = (phase_reg == PH_GMASK) ? rx_byte[NUM_GROUPS-1:0] : groups_reg;

        err_upd = err_reg;
        if (phase_reg == PH_SYNC)
        begin
            err_upd = (rx_byte == SYNC_BYTE) ? ST_OK : ST_SYNC;
        end
        else if (phase_reg == PH_TMASK && mask_odd_reg && err_reg == ST_OK && unsup)
        begin
            err_upd = ST_UNSUP;
        end

        start_payload = ((phase_reg == PH_GMASK) && !(|groups_next))
                      || ((phase_reg == PH_TMASK) && mask_odd_reg && !(|tm_rest));

        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            avail[g] = groups_next[g] ? masks_next[g] : '0;
        end

        seek_group = start_payload ? '0 : cur_group_reg;
        seek_type  = start_payload ? '0
                   : ({1'b0, cur_type_reg} + {{TYPE_W{1'b0}}, 1'b1});
    end

    imu_pkt_seek u_seek (
        .avail      (avail),
        .from_group (seek_group),
        .from_type  (seek_type),
        .result     (seek)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        mask_odd_next  = mask_odd_reg;
        cur_group_next = cur_group_reg;
        cur_type_next  = cur_type_reg;
        bif_next       = bif_reg;
        crc_next       = crc_upd;
        err_next       = err_upd;
        pkt_cnt_next   = pkt_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        bif_inc        = bif_reg + {{(BIDX_W-1){1'b0}}, 1'b1};
        status         = ST_OK;
        res_valid      = 1'b0;
        res            = '0;

        case (phase_reg)
            PH_SYNC:
            begin
                crc_next   = '0;
                phase_next = (rx_byte == SYNC_BYTE) ? PH_GMASK : PH_TRAILER;
            end
            PH_GMASK:
            begin
                mask_odd_next = 1'b0;
                if (|groups_next)
                begin
                    cur_group_next = ffs_group(groups_next);
                    phase_next     = PH_TMASK;
                end
            end
            PH_TMASK:
            begin
                mask_odd_next = ~mask_odd_reg;
                if (mask_odd_reg && (|tm_rest))
                begin
                    cur_group_next = ffs_group(tm_rest);
                end
            end
            PH_PAYLOAD:
            begin
                if (!eop)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_DATA;
                    res.group_index  = cur_group_reg;
                    res.type_index   = cur_type_reg;
                    res.byte_index   = bif_reg;
                    res.payload_byte = rx_byte;
                    bif_next         = bif_inc;
                    if (bif_inc >= TYPE_LEN[cur_group_reg][cur_type_reg])
                    begin
                        if (seek.found)
                        begin
                            cur_group_next = seek.grp;
                            cur_type_next  = seek.typ;
                            bif_next       = '0;
                        end
                        else
                        begin
                            phase_next = PH_TRAILER;
                        end
                    end
                end
            end
            PH_TRAILER:
            begin
                phase_next = PH_TRAILER;
            end
            default:
            begin
                phase_next = PH_TRAILER;
            end
        endcase

        if (start_payload)
        begin
            if (err_upd == ST_OK && seek.found)
            begin
                phase_next     = PH_PAYLOAD;
                cur_group_next = seek.grp;
                cur_type_next  = seek.typ;
                bif_next       = '0;
            end
            else
            begin
                phase_next = PH_TRAILER;
            end
        end

        if (eop)
        begin
            if (err_upd == ST_SYNC)
            begin
                status = ST_SYNC;
            end
            else if (crc_next != '0)
            begin
                status = ST_CRC;
            end
            else if (err_upd == ST_UNSUP)
            begin
                status = ST_UNSUP;
            end
            else if (phase_next == PH_GMASK || phase_next == PH_TMASK
                     || phase_next == PH_PAYLOAD)
            begin
                status = ST_TRUNC;
            end
            else
            begin
                status = ST_OK;
            end

            pkt_cnt_next = pkt_cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
            if (status != ST_OK)
            begin
                err_cnt_next = err_cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
            end

            res_valid         = 1'b1;
            res               = '0;
            res.kind          = KIND_STATUS;
            res.packet_status = status;
            res.packets_seen  = pkt_cnt_next;
            res.errors_seen   = err_cnt_next;

            phase_next = PH_SYNC;
            err_next   = ST_OK;
            crc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC;
            groups_reg    <= '0;
            mask_odd_reg  <= 1'b0;
            cur_group_reg <= '0;
            cur_type_reg  <= '0;
            bif_reg       <= '0;
            crc_reg       <= '0;
            err_reg       <= ST_OK;
            pkt_cnt_reg   <= '0;
            err_cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            groups_reg    <= groups_next;
            mask_odd_reg  <= mask_odd_next;
            cur_group_reg <= cur_group_next;
            cur_type_reg  <= cur_type_next;
            bif_reg       <= bif_next;
            crc_reg       <= crc_next;
            err_reg       <= err_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            err_cnt_reg   <= err_cnt_next;
        end
    end

    // type masks: only masks written earlier in the same packet are read
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            masks_reg <= masks_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/imu_binary_packet_parser.sv =====
// Top level of the group-mask binary packet parser with CRC-16/XMODEM check.
// Input item register, imu_pkt_parser core, output result register.
// Depends on imu_pkt_pkg, imu_pkt_parser, imu_pkt_seek.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = rx_byte, s_tlast = end_of_packet
//  m_*     | out | m_tvalid/m_tready  | m_tdata = result fields, m_tuser = kind
//
// One item per cycle while m_tready holds; items pass the input, then the output register.
// The per-byte CRC update and the next-field search sit between the input and
// result registers. Reset clears the phase, CRC, counters and both valids;
// type masks are written before they are read in each packet.
// A stalled result holds m_tdata; the input register still takes one more item,
// after which s_tready follows m_tready.
`timescale 1ns / 1ps
`default_nettype none

module imu_binary_packet_parser
    import imu_pkt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [2:0] group_index, [6:3] type_index,
                                   // [11:7] byte_index, [19:12] payload_byte,
                                   // [22:20] packet_status, [38:23] packets_seen,
                                   // [54:39] errors_seen, [55] zero
    output logic        m_tuser    // kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        out_kind_reg;

    logic        advance;
    logic        res_valid;
    result_t     res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    imu_pkt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .eop       (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, res.errors_seen, res.packets_seen, res.packet_status,
                             res.payload_byte, res.byte_index, res.type_index,
                             res.group_index};
            out_kind_reg <= res.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire
